// File: hw/rtl/line_segment_rasterizer_defines.svh
// Assertion macros for the line rasterizer RTL.
// Needs i_clk and i_rst_n in the scope of each use.
`ifndef LINE_SEGMENT_RASTERIZER_DEFINES_SVH
`define LINE_SEGMENT_RASTERIZER_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define LSR_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked out of reset.
`define LSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/lsr_pkg.sv
// Shared types and constants of the line rasterizer.
// No dependencies; used by every module of the block.
package lsr_pkg;

    localparam int ORIGIN_DEF    = 128;
    localparam int FRAC_BITS_DEF = 16;
    localparam int COLUMN_OFFSET = 128;

    localparam int COORD_W    = 8;   // endpoint coordinate width
    localparam int Y_INT_W    = 11;  // integer bits of the y accumulator
    localparam int T_INT_W    = 13;  // integer bits of the row term
    localparam int COL_W      = 8;
    localparam int ROW_W      = 9;
    localparam int IN_DATA_W  = 8;
    localparam int OUT_DATA_W = 24;
    localparam int CFG_IDX_W  = 8;

    localparam logic [CFG_IDX_W-1:0] REG_FIRST_X  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_X = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_Y  = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SECOND_Y = 8'd3;

    typedef enum logic [1:0] {
        EMIT_FIRST,
        EMIT_SECOND,
        EMIT_RUN
    } t_emit_sel;

    typedef struct packed {
        logic      load;   // latch endpoints, start slope divide if sloped
        logic      step;   // advance the run point
        logic      emit;   // load the output register
        t_emit_sel sel;
        logic      last;
    } t_cmd;

    typedef struct packed {
        logic sloped_cfg;  // programmed endpoints make a sloped line
        logic run_now;     // run condition on current point
        logic run_next;    // run condition after one advance
        logic div_done;
    } t_status;

endpackage

// File: hw/rtl/line_segment_rasterizer.sv
// Restart: first endpoint is in the output register in the cycle after the request;
//   a sloped line then holds off requests until the bit-serial slope divide is done.
// Tick: a pixel per request, one per cycle unless the output stalls; none when idle.
// Synchronous active-low reset: endpoints 0, line finished, output empty.
// Top level of the line rasterizer; uses lsr_pkg, lsr_ctrl, lsr_dp (lsr_div).
module line_segment_rasterizer #(
    parameter int ORIGIN    = lsr_pkg::ORIGIN_DEF,
    parameter int FRAC_BITS = lsr_pkg::FRAC_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // request stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [lsr_pkg::IN_DATA_W-1:0]    s_axis_tdata,   // [0] restart, rest zero
    // pixel stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [lsr_pkg::OUT_DATA_W-1:0]   m_axis_tdata,   // [7:0] column, [16:8] row
    output logic                             m_axis_tlast,   // last pixel of the line
    // register writes: 0 first_x, 1 second_x, 2 first_y, 3 second_y
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [lsr_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [lsr_pkg::COORD_W-1:0]      i_cfg_data
);
    lsr_pkg::t_cmd    w_cmd;
    lsr_pkg::t_status w_status;
    logic [lsr_pkg::COL_W-1:0] w_column;
    logic [lsr_pkg::ROW_W-1:0] w_row;

    // Register writes are always taken; new endpoints apply at the next restart.
    assign o_cfg_ready = 1'b1;

    // Controller tracks the line phase (second endpoint, run, finished) and
    // owns the output valid; the output register lets a request be taken in
    // the same cycle the pending pixel leaves.
    lsr_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (s_axis_tvalid),
        .i_in_restart (s_axis_tdata[0]),
        .o_in_ready   (s_axis_tready),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .i_status     (w_status),
        .o_cmd        (w_cmd)
    );

    // Datapath: endpoint swap, slope divide, DDA step, screen mapping.
    lsr_dp #(
        .ORIGIN    (ORIGIN),
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_column    (w_column),
        .o_row       (w_row),
        .o_last      (m_axis_tlast)
    );

    assign m_axis_tdata = {{(lsr_pkg::OUT_DATA_W - lsr_pkg::ROW_W - lsr_pkg::COL_W){1'b0}},
                           w_row, w_column};

endmodule

// File: hw/rtl/lsr_div.sv
// Restoring divider, one quotient bit per cycle, unsigned.
// Uses lsr_pkg for the divisor width.
module lsr_div #(
    parameter int DIVIDEND_W = lsr_pkg::FRAC_BITS_DEF + lsr_pkg::COORD_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [DIVIDEND_W-1:0]         i_dividend,
    input  logic [lsr_pkg::COORD_W-1:0]   i_divisor,
    output logic                          o_done,
    output logic [DIVIDEND_W-1:0]         o_quotient
);
    localparam int XW = lsr_pkg::COORD_W;
    localparam int CW = $clog2(DIVIDEND_W + 1);

    logic [DIVIDEND_W-1:0] r_quo;
    logic [XW-1:0]         r_rem;
    logic [XW-1:0]         r_div;
    logic [CW-1:0]         r_cnt;
    logic                  r_busy;
    logic                  r_done;
    logic [XW:0]           w_rem_sh;
    logic                  w_ge;
    logic [XW:0]           w_diff;

    always_comb begin
        w_rem_sh = {r_rem, r_quo[DIVIDEND_W-1]};
        w_ge     = w_rem_sh >= {1'b0, r_div};
        w_diff   = w_rem_sh - {1'b0, r_div};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CW'(1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DIVIDEND_W);
            end else if (r_busy) begin
                r_cnt <= r_cnt - CW'(1);
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_quo <= {r_quo[DIVIDEND_W-2:0], w_ge};
            r_rem <= w_ge ? w_diff[XW-1:0] : w_rem_sh[XW-1:0];
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

// File: hw/rtl/lsr_dp.sv
// Line rasterizer datapath: endpoint registers, run state, pixel mapping.
// Uses lsr_pkg and instantiates lsr_div for the slope.
module lsr_dp #(
    parameter int ORIGIN    = lsr_pkg::ORIGIN_DEF,
    parameter int FRAC_BITS = lsr_pkg::FRAC_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_valid,
    input  logic [lsr_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [lsr_pkg::COORD_W-1:0]     i_cfg_data,
    input  lsr_pkg::t_cmd                   i_cmd,
    output lsr_pkg::t_status                o_status,
    output logic [lsr_pkg::COL_W-1:0]       o_column,
    output logic [lsr_pkg::ROW_W-1:0]       o_row,
    output logic                            o_last
);
    localparam int XW = lsr_pkg::COORD_W;
    localparam int YW = FRAC_BITS + lsr_pkg::Y_INT_W;
    localparam int TW = FRAC_BITS + lsr_pkg::T_INT_W;
    localparam int DW = FRAC_BITS + XW;
    localparam logic signed [YW-1:0] ONE_Q =
        {{(lsr_pkg::Y_INT_W-1){1'b0}}, 1'b1, {FRAC_BITS{1'b0}}};
    localparam logic signed [TW-1:0] ORIGIN_Q = TW'(ORIGIN) << FRAC_BITS;
    localparam logic signed [TW-1:0] ROUND_Q  = TW'((2**FRAC_BITS) - 1);

    typedef enum logic [1:0] {
        KIND_HORIZ,
        KIND_VERT,
        KIND_RISE,
        KIND_FALL
    } t_kind;

    function automatic logic signed [YW-1:0] to_q(input logic signed [XW-1:0] v);
        to_q = {{(YW-FRAC_BITS-XW){v[XW-1]}}, v, {FRAC_BITS{1'b0}}};
    endfunction

    function automatic logic in_run(input t_kind k, input logic signed [XW:0] x,
                                    input logic signed [YW-1:0] y,
                                    input logic signed [XW:0] ex,
                                    input logic signed [YW-1:0] lq);
        case (k)
            KIND_HORIZ: in_run = x < ex;
            KIND_VERT:  in_run = y < lq;
            KIND_RISE:  in_run = (y < lq) && (x <= ex);
            default:    in_run = (y > lq) && (x <= ex);
        endcase
    endfunction

    // endpoint registers
    logic signed [XW-1:0] r_x1, r_x2, r_y1, r_y2;

    // run state
    t_kind                r_kind;
    logic signed [XW:0]   r_cur_x;
    logic signed [XW-1:0] r_end_x, r_end_y, r_lim;
    logic signed [YW-1:0] r_y_acc;
    logic signed [YW-1:0] r_slope;

    // output payload
    logic [lsr_pkg::COL_W-1:0] r_column;
    logic [lsr_pkg::ROW_W-1:0] r_row;
    logic                      r_last;

    logic                 w_swap, w_horiz, w_vert, w_sloped;
    logic signed [XW-1:0] w_ax1, w_ay1, w_ax2, w_ay2, w_y_lo, w_y_hi;
    logic signed [XW:0]   w_dx, w_dy, w_dy_mag;
    t_kind                w_kind_ld;
    logic signed [XW:0]   w_x_nx, w_end_x9;
    logic signed [YW-1:0] w_y_nx, w_lim_q;
    logic signed [XW:0]   w_px;
    logic signed [YW-1:0] w_py;
    logic signed [TW-1:0] w_t, w_tr;
    logic [XW:0]          w_col9;
    logic                 w_div_done;
    logic [DW-1:0]        w_quo;
    logic signed [YW-1:0] w_quo_ext;

    // swap so that x runs upward, classify the line
    always_comb begin
        w_swap    = r_x1 > r_x2;
        w_ax1     = w_swap ? r_x2 : r_x1;
        w_ay1     = w_swap ? r_y2 : r_y1;
        w_ax2     = w_swap ? r_x1 : r_x2;
        w_ay2     = w_swap ? r_y1 : r_y2;
        w_dx      = {w_ax2[XW-1], w_ax2} - {w_ax1[XW-1], w_ax1};
        w_dy      = {w_ay2[XW-1], w_ay2} - {w_ay1[XW-1], w_ay1};
        w_dy_mag  = w_dy[XW] ? -w_dy : w_dy;
        w_horiz   = w_ay1 == w_ay2;
        w_vert    = !w_horiz && (w_ax1 == w_ax2);
        w_sloped  = !w_horiz && !w_vert;
        w_y_lo    = (w_ay1 < w_ay2) ? w_ay1 : w_ay2;
        w_y_hi    = (w_ay1 < w_ay2) ? w_ay2 : w_ay1;
        if (w_horiz) begin
            w_kind_ld = KIND_HORIZ;
        end else if (w_vert) begin
            w_kind_ld = KIND_VERT;
        end else if (w_ay1 < w_ay2) begin
            w_kind_ld = KIND_RISE;
        end else begin
            w_kind_ld = KIND_FALL;
        end
    end

    // one advance of the run point
    always_comb begin
        w_end_x9 = {r_end_x[XW-1], r_end_x};
        w_lim_q  = to_q(r_lim);
        case (r_kind)
            KIND_HORIZ: begin
                w_x_nx = r_cur_x + (XW+1)'(1);
                w_y_nx = r_y_acc;
            end
            KIND_VERT: begin
                w_x_nx = r_cur_x;
                w_y_nx = r_y_acc + ONE_Q;
            end
            default: begin
                w_x_nx = r_cur_x + (XW+1)'(1);
                w_y_nx = r_y_acc + r_slope;
            end
        endcase
    end

    // pixel mapping: column = x + offset, row = origin - y toward zero
    always_comb begin
        case (i_cmd.sel)
            lsr_pkg::EMIT_FIRST: begin
                w_px = {w_ax1[XW-1], w_ax1};
                w_py = to_q(w_ay1);
            end
            lsr_pkg::EMIT_SECOND: begin
                w_px = w_end_x9;
                w_py = to_q(r_end_y);
            end
            default: begin
                w_px = r_cur_x;
                w_py = r_y_acc;
            end
        endcase
        w_t    = ORIGIN_Q - {{(TW-YW){w_py[YW-1]}}, w_py};
        w_tr   = w_t[TW-1] ? (w_t + ROUND_Q) : w_t;
        w_col9 = w_px + (XW+1)'(lsr_pkg::COLUMN_OFFSET);
    end

    lsr_div #(
        .DIVIDEND_W (DW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.load && w_sloped),
        .i_dividend ({w_dy_mag[XW-1:0], {FRAC_BITS{1'b0}}}),
        .i_divisor  (w_dx[XW-1:0]),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    assign w_quo_ext = {{(YW-DW){1'b0}}, w_quo};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_x1    <= '0;
            r_x2    <= '0;
            r_y1    <= '0;
            r_y2    <= '0;
            r_kind  <= KIND_HORIZ;
            r_cur_x <= '0;
            r_end_x <= '0;
            r_end_y <= '0;
            r_lim   <= '0;
            r_y_acc <= '0;
            r_slope <= '0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    lsr_pkg::REG_FIRST_X:  r_x1 <= i_cfg_data;
                    lsr_pkg::REG_SECOND_X: r_x2 <= i_cfg_data;
                    lsr_pkg::REG_FIRST_Y:  r_y1 <= i_cfg_data;
                    lsr_pkg::REG_SECOND_Y: r_y2 <= i_cfg_data;
                    default: ;
                endcase
            end
            if (i_cmd.load) begin
                r_kind  <= w_kind_ld;
                r_cur_x <= {w_ax1[XW-1], w_ax1};
                r_end_x <= w_ax2;
                r_end_y <= w_ay2;
                r_lim   <= w_vert ? w_y_hi : w_ay2;
                r_y_acc <= w_vert ? to_q(w_y_lo) : to_q(w_ay1);
                r_slope <= '0;
            end else if (i_cmd.step) begin
                r_cur_x <= w_x_nx;
                r_y_acc <= w_y_nx;
            end
            if (w_div_done) begin
                r_slope <= (r_kind == KIND_FALL) ? -w_quo_ext : w_quo_ext;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_column <= w_col9[lsr_pkg::COL_W-1:0];
            r_row    <= w_tr[FRAC_BITS +: lsr_pkg::ROW_W];
            r_last   <= i_cmd.last;
        end
    end

    always_comb begin
        o_status.sloped_cfg = w_sloped;
        o_status.run_now    = in_run(r_kind, r_cur_x, r_y_acc, w_end_x9, w_lim_q);
        o_status.run_next   = in_run(r_kind, w_x_nx, w_y_nx, w_end_x9, w_lim_q);
        o_status.div_done   = w_div_done;
    end

    assign o_column = r_column;
    assign o_row    = r_row;
    assign o_last   = r_last;

endmodule

// File: hw/rtl/lsr_ctrl.sv
// Line rasterizer controller: line phase, request handshake, output valid.
// Uses lsr_pkg and the assertion macros header.
`include "line_segment_rasterizer_defines.svh"

module lsr_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  logic             i_in_restart,
    output logic             o_in_ready,
    input  logic             i_out_ready,
    output logic             o_out_valid,
    input  lsr_pkg::t_status i_status,
    output lsr_pkg::t_cmd    o_cmd
);
    typedef enum logic [1:0] {
        ST_IDLE,    // line finished
        ST_SECOND,  // second endpoint next
        ST_RUN,     // run point next
        ST_DIV      // slope divide in flight
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   w_accept;

    assign o_in_ready = (r_state != ST_DIV) && (!r_out_valid || i_out_ready);
    assign w_accept   = i_in_valid && o_in_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        if (w_accept) begin
            if (i_in_restart) begin
                o_cmd.load = 1'b1;
                o_cmd.emit = 1'b1;
                o_cmd.sel  = lsr_pkg::EMIT_FIRST;
                n_state    = i_status.sloped_cfg ? ST_DIV : ST_SECOND;
            end else begin
                case (r_state)
                    ST_SECOND: begin
                        o_cmd.emit = 1'b1;
                        o_cmd.sel  = lsr_pkg::EMIT_SECOND;
                        o_cmd.last = !i_status.run_now;
                        n_state    = i_status.run_now ? ST_RUN : ST_IDLE;
                    end
                    ST_RUN: begin
                        o_cmd.emit = 1'b1;
                        o_cmd.step = 1'b1;
                        o_cmd.sel  = lsr_pkg::EMIT_RUN;
                        o_cmd.last = !i_status.run_next;
                        n_state    = i_status.run_next ? ST_RUN : ST_IDLE;
                    end
                    default: ;  // idle tick, no pixel
                endcase
            end
        end else if ((r_state == ST_DIV) && i_status.div_done) begin
            n_state = ST_SECOND;
        end
        n_out_valid = o_cmd.emit || (r_out_valid && !i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

    `LSR_ASSERT_IMPL(a_emit_room, o_cmd.emit, !r_out_valid || i_out_ready, "pixel overwrote pending result")
    `LSR_ASSERT_NEXT(a_div_exit, (r_state == ST_DIV) && i_status.div_done, r_state == ST_SECOND, "divide end not followed")
    `LSR_ASSERT_NEXT(a_sloped_div, o_cmd.load && i_status.sloped_cfg, (r_state == ST_DIV) && r_out_valid, "sloped restart skipped divide")
    `LSR_ASSERT_IMPL(a_step_in_run, o_cmd.step, (r_state == ST_RUN) && !o_cmd.load, "step outside run phase")

endmodule
